[rtl/msdp_pkg.sv]
// Shared types, constants and pipeline depths for the multi-slit diffraction unit.
// No dependencies; imported by the top module, msdp_sine and msdp_turn.
`default_nettype none

package msdp_pkg;

    // Q2.30 unity and radian-to-turn scale factors
    localparam logic [30:0] ONE_Q30        = 31'h4000_0000;
    localparam logic [29:0] RAD_TO_TURN32  = 30'h28BE_60DC;
    localparam logic [31:0] RAD_TO_TURN_HI = 32'h28BE_60DB;
    localparam logic [31:0] RAD_TO_TURN_LO = 32'h9391_054A;

    // phases below 2^-8 rad use the series form of sin(x)/x
    localparam int unsigned SMALL_PHASE_W  = 24;
    // floor(x/6) for x below 2^14 as (x * DIV6_RECIP) >> 18
    localparam logic [15:0] DIV6_RECIP     = 16'd43691;

    // Horner coefficients of the sine series, highest order first
    localparam int unsigned SIN_TERMS = 6;
    localparam logic [30:0] SIN_COEF [0:SIN_TERMS-1] = '{
        31'd3864, 31'd172272, 31'd5026995, 31'd85569306,
        31'd693598668, 31'd1686629713
    };

    // stage counts and datapath widths
    localparam int unsigned SIN_LAT   = SIN_TERMS + 2;
    localparam int unsigned TURN_LAT  = 3;
    localparam int unsigned QUO_W     = 31;
    localparam int unsigned DIV_LAT   = QUO_W;
    localparam int unsigned SINC_DW   = 64;
    localparam int unsigned GRAT_DW   = 42;
    localparam int unsigned PIPE_LAT  = 1 + SIN_LAT + 2 + TURN_LAT + 1 + SIN_LAT + 1
                                        + DIV_LAT + 3;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_SLIT_COUNT   = 3'd0,
        CFG_PEAK_AMP     = 3'd1,
        CFG_SLIT_WIDTH   = 3'd2,
        CFG_SLIT_SPACING = 3'd3,
        CFG_WAVE_NUMBER  = 3'd4
    } t_cfg_idx;

    // reset values of the configuration registers
    localparam logic [10:0] RST_SLIT_COUNT   = 11'd1;
    localparam logic [31:0] RST_PEAK_AMP     = 32'd65536;
    localparam logic [31:0] RST_SLIT_WIDTH   = 32'd65536;
    localparam logic [31:0] RST_SLIT_SPACING = 32'd131072;
    localparam logic [31:0] RST_WAVE_NUMBER  = 32'd65536;

    // per-item flags carried alongside the divider chains
    typedef struct packed {
        logic        beta_small;
        logic [30:0] small_m;
        logic        sb_neg;
        logic        sd_zero;
        logic        ta_nz;
        logic        sn_neg;
        logic        sd_neg;
    } t_side;

endpackage

`default_nettype wire

[rtl/multi_slit_diffraction_pattern_unit.sv]
// Multi-slit diffraction: one angle in, amplitude and irradiance out.
// An item is taken every cycle while busy is low; the two 31-cell division chains
// and the sines are fully pipelined. The receiver cannot stall; results are
// strobed by o_valid for one cycle. Synchronous active-low reset clears the
// pipeline valids and loads the default configuration. Depends on msdp_pkg
// and all msdp_* modules.
`default_nettype none

module multi_slit_diffraction_pattern_unit
    import msdp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [15:0] i_angle,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [31:0]        i_cfg_data,
    output logic                    o_valid,
    output logic signed [31:0]      o_amplitude,
    output logic        [31:0]      o_irradiance
);

    // configuration
    logic [10:0] r_slit_count;
    logic [31:0] r_peak_amp;
    logic [31:0] r_slit_width;
    logic [31:0] r_slit_spacing;
    logic [31:0] r_wave_number;
    logic [63:0] r_kb;
    logic [63:0] r_kd;
    logic [10:0] w_n;
    logic        r_busy;

    logic [PIPE_LAT-1:0] r_vld;

    logic [16:0] w_amag;
    logic [46:0] w_tprod;
    logic [31:0] r_t;
    logic [30:0] w_s_mag;
    logic        w_s_neg_unused;

    logic [62:0] r_pl_b, r_ph_b, r_pl_d, r_ph_d;
    logic [95:0] w_sum_b, w_sum_d;
    logic [63:0] r_beta, r_alpha;

    logic [13:0] r_sq;
    logic        r_small12, r_small13, r_small14;
    logic [47:0] w_bsq;
    logic [29:0] w_q6p;
    logic [11:0] r_q6;
    logic [30:0] r_smallm;

    logic [31:0] w_tb, w_ta;
    logic [31:0] r_tb15, r_ta15, r_nta;
    logic [42:0] w_nta;
    logic        r_ta_nz15;

    logic [30:0] w_sb_mag, w_sd_mag, w_sn_mag;
    logic        w_sb_neg, w_sd_neg, w_sn_neg;
    logic [63:0] w_beta23;
    logic        w_ta_nz23;
    logic [31:0] w_small23;

    logic [30:0] r_sb_mag, r_sn_mag;
    logic [63:0] r_beta24;
    logic [41:0] r_gd;
    t_side       r_side;
    t_side       w_side55;

    logic [QUO_W-1:0] w_sinc_q, w_grat_q;
    logic             w_sinc_ovf, w_grat_ovf;

    logic [30:0] w_sinc_m, w_grat_m;
    logic        w_sinc_neg, w_grat_neg;
    logic [61:0] w_prod;
    logic [30:0] r_prod;
    logic        r_neg56;
    logic [62:0] w_amp;
    logic [32:0] r_amp;
    logic        r_neg57;
    logic [32:0] w_amp_cap;
    logic [47:0] w_amp_sq;
    logic [31:0] r_amplitude;
    logic [31:0] r_irradiance;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slit_count   <= RST_SLIT_COUNT;
            r_peak_amp     <= RST_PEAK_AMP;
            r_slit_width   <= RST_SLIT_WIDTH;
            r_slit_spacing <= RST_SLIT_SPACING;
            r_wave_number  <= RST_WAVE_NUMBER;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SLIT_COUNT:   r_slit_count   <= i_cfg_data[10:0];
                CFG_PEAK_AMP:     r_peak_amp     <= i_cfg_data;
                CFG_SLIT_WIDTH:   r_slit_width   <= i_cfg_data;
                CFG_SLIT_SPACING: r_slit_spacing <= i_cfg_data;
                CFG_WAVE_NUMBER:  r_wave_number  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // hold k*b and k*d ready; they follow the registers in the next cycle
    always_ff @(posedge i_clk) begin
        r_kb <= 64'(r_wave_number) * 64'(r_slit_width);
        r_kd <= 64'(r_wave_number) * 64'(r_slit_spacing);
    end

    assign w_n = (r_slit_count == 11'd0) ? 11'd1 : r_slit_count;

    // busy is reset passed through a register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end
    assign busy = r_busy;

    // advance the item valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_LAT-2:0], start && !r_busy};
        end
    end

    // angle magnitude to turns
    assign w_amag  = i_angle[15] ? (17'h10000 - {1'b0, i_angle}) : {1'b0, i_angle};
    assign w_tprod = 47'(w_amag) * 47'(RAD_TO_TURN32);

    always_ff @(posedge i_clk) begin
        r_t <= w_tprod[45:14];
    end

    msdp_sine u_sin_theta (
        .i_clk  (i_clk),
        .i_turn (r_t),
        .o_mag  (w_s_mag),
        .o_neg  (w_s_neg_unused)
    );

    // phases: half of k*x times sin(theta), split in two partial products
    always_ff @(posedge i_clk) begin
        r_pl_b <= 63'(r_kb[31:0])  * 63'(w_s_mag);
        r_ph_b <= 63'(r_kb[63:32]) * 63'(w_s_mag);
        r_pl_d <= 63'(r_kd[31:0])  * 63'(w_s_mag);
        r_ph_d <= 63'(r_kd[63:32]) * 63'(w_s_mag);
    end

    assign w_sum_b = {1'b0, r_ph_b, 32'd0} + 96'(r_pl_b);
    assign w_sum_d = {1'b0, r_ph_d, 32'd0} + 96'(r_pl_d);

    always_ff @(posedge i_clk) begin
        r_beta  <= w_sum_b[94:31];
        r_alpha <= w_sum_d[94:31];
    end

    // small-phase series term for sin(beta)/beta
    assign w_bsq = 48'(r_beta[23:0]) * 48'(r_beta[23:0]);
    assign w_q6p = 30'(r_sq) * 30'(DIV6_RECIP);

    always_ff @(posedge i_clk) begin
        r_sq      <= w_bsq[47:34];
        r_small12 <= (r_beta[63:SMALL_PHASE_W] == '0);
        r_q6      <= w_q6p[29:18];
        r_small13 <= r_small12;
        r_smallm  <= ONE_Q30 - 31'(r_q6);
        r_small14 <= r_small13;
    end

    msdp_turn u_turn_beta (
        .i_clk   (i_clk),
        .i_phase (r_beta),
        .o_turn  (w_tb)
    );

    msdp_turn u_turn_alpha (
        .i_clk   (i_clk),
        .i_phase (r_alpha),
        .o_turn  (w_ta)
    );

    // N times the alpha turn, wrapping
    assign w_nta = 43'(w_n) * 43'(w_ta);

    always_ff @(posedge i_clk) begin
        r_tb15    <= w_tb;
        r_ta15    <= w_ta;
        r_nta     <= w_nta[31:0];
        r_ta_nz15 <= (w_ta != 32'd0);
    end

    msdp_sine u_sin_beta (
        .i_clk  (i_clk),
        .i_turn (r_tb15),
        .o_mag  (w_sb_mag),
        .o_neg  (w_sb_neg)
    );

    msdp_sine u_sin_alpha (
        .i_clk  (i_clk),
        .i_turn (r_ta15),
        .o_mag  (w_sd_mag),
        .o_neg  (w_sd_neg)
    );

    msdp_sine u_sin_nalpha (
        .i_clk  (i_clk),
        .i_turn (r_nta),
        .o_mag  (w_sn_mag),
        .o_neg  (w_sn_neg)
    );

    // line up beta and flags with the sine outputs
    msdp_delay #(
        .WIDTH (64),
        .DEPTH (TURN_LAT + 1 + SIN_LAT)
    ) u_dly_beta (
        .i_clk (i_clk),
        .i_d   (r_beta),
        .o_q   (w_beta23)
    );

    msdp_delay #(
        .WIDTH (1),
        .DEPTH (SIN_LAT)
    ) u_dly_ta (
        .i_clk (i_clk),
        .i_d   (r_ta_nz15),
        .o_q   (w_ta_nz23)
    );

    msdp_delay #(
        .WIDTH (32),
        .DEPTH (1 + SIN_LAT)
    ) u_dly_small (
        .i_clk (i_clk),
        .i_d   ({r_small14, r_smallm}),
        .o_q   (w_small23)
    );

    // divider operands and side flags
    always_ff @(posedge i_clk) begin
        r_sb_mag          <= w_sb_mag;
        r_sn_mag          <= w_sn_mag;
        r_beta24          <= w_beta23;
        r_gd              <= 42'(w_n) * 42'(w_sd_mag);
        r_side.beta_small <= w_small23[31];
        r_side.small_m    <= w_small23[30:0];
        r_side.sb_neg     <= w_sb_neg;
        r_side.sd_zero    <= (w_sd_mag == 31'd0);
        r_side.ta_nz      <= w_ta_nz23;
        r_side.sn_neg     <= w_sn_neg;
        r_side.sd_neg     <= w_sd_neg;
    end

    // sin(beta) * 2^32 / beta
    msdp_divider #(
        .DIV_W (SINC_DW),
        .QUO_W (QUO_W)
    ) u_div_sinc (
        .i_clk (i_clk),
        .i_top (SINC_DW'({r_sb_mag, 1'b0})),
        .i_low ('0),
        .i_div (r_beta24),
        .o_quo (w_sinc_q),
        .o_ovf (w_sinc_ovf)
    );

    // sin(N alpha) * 2^30 / (N sin(alpha))
    msdp_divider #(
        .DIV_W (GRAT_DW),
        .QUO_W (QUO_W)
    ) u_div_grat (
        .i_clk (i_clk),
        .i_top (GRAT_DW'(r_sn_mag[30:1])),
        .i_low ({r_sn_mag[0], 30'd0}),
        .i_div (r_gd),
        .o_quo (w_grat_q),
        .o_ovf (w_grat_ovf)
    );

    msdp_delay #(
        .WIDTH ($bits(t_side)),
        .DEPTH (DIV_LAT)
    ) u_dly_side (
        .i_clk (i_clk),
        .i_d   (r_side),
        .o_q   (w_side55)
    );

    // pick the factors, cap at one, combine signs
    always_comb begin
        if (w_side55.beta_small) begin
            w_sinc_m   = w_side55.small_m;
            w_sinc_neg = 1'b0;
        end else begin
            w_sinc_m   = (w_sinc_ovf || (w_sinc_q > ONE_Q30)) ? ONE_Q30 : w_sinc_q;
            w_sinc_neg = w_side55.sb_neg;
        end
        if (w_side55.sd_zero) begin
            w_grat_m   = ONE_Q30;
            w_grat_neg = w_side55.ta_nz && !w_n[0];
        end else begin
            w_grat_m   = (w_grat_ovf || (w_grat_q > ONE_Q30)) ? ONE_Q30 : w_grat_q;
            w_grat_neg = w_side55.sn_neg != w_side55.sd_neg;
        end
    end

    assign w_prod = 62'(w_sinc_m) * 62'(w_grat_m);

    always_ff @(posedge i_clk) begin
        r_prod  <= w_prod[60:30];
        r_neg56 <= w_sinc_neg != w_grat_neg;
    end

    // scale by the peak amplitude
    assign w_amp = 63'(r_peak_amp) * 63'(r_prod);

    always_ff @(posedge i_clk) begin
        r_amp   <= w_amp[62:30];
        r_neg57 <= r_neg56 && (r_prod != 31'd0);
    end

    // saturate amplitude, square for irradiance
    assign w_amp_cap = (r_amp > 33'h0_8000_0000) ? 33'h0_8000_0000 : r_amp;
    assign w_amp_sq  = 48'(r_amp[23:0]) * 48'(r_amp[23:0]);

    always_ff @(posedge i_clk) begin
        if (!r_neg57) begin
            r_amplitude <= (r_amp > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : r_amp[31:0];
        end else begin
            r_amplitude <= ~w_amp_cap[31:0] + 32'd1;
        end
        r_irradiance <= (r_amp[32:24] != 9'd0) ? 32'hFFFF_FFFF : w_amp_sq[47:16];
    end

    assign o_valid      = r_vld[PIPE_LAT-1];
    assign o_amplitude  = r_amplitude;
    assign o_irradiance = r_irradiance;

endmodule

`default_nettype wire

[rtl/msdp_delay.sv]
// Fixed-depth register delay line for payload that rides beside the pipeline.
// No package dependency.
`default_nettype none

module msdp_delay #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 1
) (
    input  wire logic             i_clk,
    input  wire logic [WIDTH-1:0] i_d,
    output logic      [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_pipe [0:DEPTH-1];

    // shift one place per cycle
    always_ff @(posedge i_clk) begin
        r_pipe[0] <= i_d;
    end

    for (genvar k = 1; k < DEPTH; k++) begin : g_tap
        always_ff @(posedge i_clk) begin
            r_pipe[k] <= r_pipe[k-1];
        end
    end

    assign o_q = r_pipe[DEPTH-1];

endmodule

`default_nettype wire

[rtl/msdp_sine.sv]
// Pipelined sine of a 32-bit turn angle: Q2.30 magnitude and sign.
// Depends on msdp_pkg for the series coefficients and stage count.
`default_nettype none

module msdp_sine
    import msdp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic [31:0] i_turn,
    output logic      [30:0] o_mag,
    output logic             o_neg
);

    logic [30:0] r_z  [0:SIN_TERMS];
    logic [1:0]  r_q  [0:SIN_TERMS];
    logic [30:0] r_z2 [1:SIN_TERMS];
    logic [30:0] r_p  [1:SIN_TERMS];
    logic [30:0] r_mag;
    logic        r_neg;

    logic [30:0] w_z;
    logic [61:0] w_zz;
    logic [61:0] w_r;

    // fold the angle into the first quadrant
    assign w_z  = i_turn[30] ? (ONE_Q30 - {1'b0, i_turn[29:0]}) : {1'b0, i_turn[29:0]};
    assign w_zz = 62'(r_z[0]) * 62'(r_z[0]);

    always_ff @(posedge i_clk) begin
        r_z[0]  <= w_z;
        r_q[0]  <= i_turn[31:30];
        r_z[1]  <= r_z[0];
        r_q[1]  <= r_q[0];
        r_z2[1] <= w_zz[60:30];
        r_p[1]  <= SIN_COEF[0];
    end

    // one Horner step per stage
    for (genvar k = 2; k <= SIN_TERMS; k++) begin : g_horner
        logic [61:0] w_hp;
        logic [31:0] w_diff;
        assign w_hp   = 62'(r_z2[k-1]) * 62'(r_p[k-1]);
        assign w_diff = {1'b0, SIN_COEF[k-1]} - w_hp[61:30];
        always_ff @(posedge i_clk) begin
            r_z[k]  <= r_z[k-1];
            r_q[k]  <= r_q[k-1];
            r_z2[k] <= r_z2[k-1];
            r_p[k]  <= w_diff[30:0];
        end
    end

    // final multiply, cap at one, sign from the upper half turn
    assign w_r = 62'(r_z[SIN_TERMS]) * 62'(r_p[SIN_TERMS]);

    always_ff @(posedge i_clk) begin
        r_mag <= (w_r[61:30] > {1'b0, ONE_Q30}) ? ONE_Q30 : w_r[60:30];
        r_neg <= r_q[SIN_TERMS][1] && (w_r[61:30] != 32'd0);
    end

    assign o_mag = r_mag;
    assign o_neg = r_neg;

endmodule

`default_nettype wire

[rtl/msdp_turn.sv]
// Converts a Q32.32 radian phase into a 32-bit turn angle in three stages.
// Depends on msdp_pkg for the radian-to-turn constant.
`default_nettype none

module msdp_turn
    import msdp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic [63:0] i_phase,
    output logic      [31:0] o_turn
);

    logic [63:0] r_pp00;
    logic [63:0] r_pp01;
    logic [63:0] r_pp10;
    logic [63:0] r_pp11;
    logic [65:0] r_mid;
    logic [31:0] r_hi;
    logic [31:0] r_turn;

    // partial products of the 64 by 64 product
    always_ff @(posedge i_clk) begin
        r_pp00 <= 64'(i_phase[31:0])  * 64'(RAD_TO_TURN_LO);
        r_pp01 <= 64'(i_phase[31:0])  * 64'(RAD_TO_TURN_HI);
        r_pp10 <= 64'(i_phase[63:32]) * 64'(RAD_TO_TURN_LO);
        r_pp11 <= 64'(i_phase[63:32]) * 64'(RAD_TO_TURN_HI);
    end

    // collect the middle column with its carry from below
    always_ff @(posedge i_clk) begin
        r_mid  <= 66'(r_pp01) + 66'(r_pp10) + 66'(r_pp00[63:32]);
        r_hi   <= r_pp11[31:0];
        r_turn <= r_hi + r_mid[63:32];
    end

    assign o_turn = r_turn;

endmodule

`default_nettype wire

[rtl/msdp_div_cell.sv]
// One restoring-division cell: one quotient bit per cycle, registered.
// No package dependency; used by msdp_divider.
`default_nettype none

module msdp_div_cell #(
    parameter int unsigned DIV_W = 64,
    parameter int unsigned QUO_W = 31
) (
    input  wire logic             i_clk,
    input  wire logic [DIV_W-1:0] i_rem,
    input  wire logic [QUO_W-1:0] i_bits,
    input  wire logic [DIV_W-1:0] i_div,
    input  wire logic             i_ovf,
    output logic      [DIV_W-1:0] o_rem,
    output logic      [QUO_W-1:0] o_bits,
    output logic      [DIV_W-1:0] o_div,
    output logic                  o_ovf
);

    logic [DIV_W:0]   w_sh;
    logic [DIV_W:0]   w_diff;
    logic             w_ge;
    logic [DIV_W-1:0] r_rem;
    logic [QUO_W-1:0] r_bits;
    logic [DIV_W-1:0] r_div;
    logic             r_ovf;

    // bring down the next dividend bit and try the subtract
    assign w_sh   = {i_rem, i_bits[QUO_W-1]};
    assign w_diff = w_sh - {1'b0, i_div};
    assign w_ge   = (w_sh >= {1'b0, i_div});

    always_ff @(posedge i_clk) begin
        r_rem  <= w_ge ? w_diff[DIV_W-1:0] : w_sh[DIV_W-1:0];
        r_bits <= {i_bits[QUO_W-2:0], w_ge};
        r_div  <= i_div;
        r_ovf  <= i_ovf;
    end

    assign o_rem  = r_rem;
    assign o_bits = r_bits;
    assign o_div  = r_div;
    assign o_ovf  = r_ovf;

endmodule

`default_nettype wire

[rtl/msdp_divider.sv]
// Chain of division cells; flags quotients that do not fit in QUO_W bits.
// Depends on msdp_div_cell.
`default_nettype none

module msdp_divider #(
    parameter int unsigned DIV_W = 64,
    parameter int unsigned QUO_W = 31
) (
    input  wire logic             i_clk,
    input  wire logic [DIV_W-1:0] i_top,
    input  wire logic [QUO_W-1:0] i_low,
    input  wire logic [DIV_W-1:0] i_div,
    output logic      [QUO_W-1:0] o_quo,
    output logic                  o_ovf
);

    logic [DIV_W-1:0] w_rem  [0:QUO_W];
    logic [QUO_W-1:0] w_bits [0:QUO_W];
    logic [DIV_W-1:0] w_div  [0:QUO_W];
    logic             w_ovf  [0:QUO_W];

    // quotient overflows when the upper dividend already reaches the divisor
    assign w_rem[0]  = i_top;
    assign w_bits[0] = i_low;
    assign w_div[0]  = i_div;
    assign w_ovf[0]  = (i_top >= i_div);

    for (genvar k = 0; k < QUO_W; k++) begin : g_cell
        msdp_div_cell #(
            .DIV_W (DIV_W),
            .QUO_W (QUO_W)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rem  (w_rem[k]),
            .i_bits (w_bits[k]),
            .i_div  (w_div[k]),
            .i_ovf  (w_ovf[k]),
            .o_rem  (w_rem[k+1]),
            .o_bits (w_bits[k+1]),
            .o_div  (w_div[k+1]),
            .o_ovf  (w_ovf[k+1])
        );
    end

    assign o_quo = w_bits[QUO_W];
    assign o_ovf = w_ovf[QUO_W];

endmodule

`default_nettype wire

[tb/tb_multi_slit_diffraction_pattern_unit.sv]
// Testbench for multi_slit_diffraction_pattern_unit: drives angles, predicts
// amplitude and irradiance in fixed point and checks every strobed result.
// Depends on msdp_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_multi_slit_diffraction_pattern_unit;
    import msdp_pkg::*;

    localparam int unsigned STALL_LIMIT = 5000;
    localparam int unsigned DRAIN_WAIT  = PIPE_LAT + 10;
    localparam longint unsigned UNITY   = 64'h4000_0000;

    typedef struct {
        logic signed [31:0] amp;
        logic        [31:0] irr;
    } t_pattern;

    // directed row: a register write, or an angle with an optional typed result
    typedef struct {
        bit                 is_write;
        t_cfg_idx           idx;
        logic        [31:0] data;
        logic signed [15:0] angle;
        bit                 typed;
        logic signed [31:0] amp;
        logic        [31:0] irr;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [15:0] i_angle;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_idx;
    logic [31:0]        i_cfg_data;
    logic               o_valid;
    logic signed [31:0] o_amplitude;
    logic        [31:0] o_irradiance;

    // grating settings as the block should hold them
    logic [10:0] n_slits;
    logic [31:0] peak_amp;
    logic [31:0] width_b;
    logic [31:0] spacing_d;
    logic [31:0] wave_k;

    t_pattern    pending_q[$];
    int          errors;
    int unsigned stall_cycles;
    bit          idle_on;

    multi_slit_diffraction_pattern_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_angle      (i_angle),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .o_amplitude  (o_amplitude),
        .o_irradiance (o_irradiance)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // sine of a 32-bit turn angle, Q2.30
    function automatic longint sine_of_turn(input logic [31:0] t);
        longint unsigned x, z, z2, p, r;
        x  = {34'd0, t[29:0]};
        z  = t[30] ? (UNITY - x) : x;
        z2 = (z * z) >> 30;
        p  = 64'd3864;
        p  = 64'd172272     - ((z2 * p) >> 30);
        p  = 64'd5026995    - ((z2 * p) >> 30);
        p  = 64'd85569306   - ((z2 * p) >> 30);
        p  = 64'd693598668  - ((z2 * p) >> 30);
        p  = 64'd1686629713 - ((z2 * p) >> 30);
        r  = (z * p) >> 30;
        if (r > UNITY)
            r = UNITY;
        return t[31] ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint unsigned magnitude(input longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    // phase in Q32.32 radians from k*x and the sine of theta
    function automatic longint unsigned phase_from(input longint unsigned kx,
                                                   input longint unsigned s);
        logic [127:0] full;
        full = {64'd0, kx} * {64'd0, s};
        return full[94:31];
    endfunction

    function automatic logic [31:0] turns_of_phase(input longint unsigned ph);
        logic [127:0] full;
        full = {64'd0, ph} * 128'h28BE60DB9391054A;
        return full[95:64];
    endfunction

    // amplitude and irradiance for one angle under the current settings
    function automatic t_pattern diffraction_at(input logic signed [15:0] angle);
        longint unsigned amag, s, n, beta, alpha, sinc_m, grat_m, prod, amp, lim;
        logic [31:0] t, ta;
        longint      sb, sd, sn;
        bit          sinc_neg, grat_neg, neg;
        t_pattern    res;
        amag = angle[15] ? longint'(-int'(angle)) : longint'(angle);
        t    = 32'((amag * 64'h28BE60DC) >> 14);
        s    = magnitude(sine_of_turn(t));
        n    = (n_slits == 0) ? 64'd1 : {53'd0, n_slits};
        beta  = phase_from({32'd0, wave_k} * {32'd0, width_b}, s);
        alpha = phase_from({32'd0, wave_k} * {32'd0, spacing_d}, s);
        sinc_neg = 1'b0;
        grat_neg = 1'b0;
        // sinc: series near zero, division elsewhere
        if (beta < 64'h100_0000) begin
            sinc_m = UNITY - (((beta * beta) >> 34) / 6);
        end else begin
            sb       = sine_of_turn(turns_of_phase(beta));
            sinc_neg = sb < 0;
            sinc_m   = (magnitude(sb) << 32) / beta;
            if (sinc_m > UNITY)
                sinc_m = UNITY;
        end
        // grating factor, with limits where sin(alpha) vanishes
        ta = turns_of_phase(alpha);
        sd = sine_of_turn(ta);
        if (sd == 0) begin
            grat_m   = UNITY;
            grat_neg = (ta != 0) && (n[0] == 1'b0);
        end else begin
            sn       = sine_of_turn(32'(n * ta));
            grat_m   = (magnitude(sn) << 30) / (n * magnitude(sd));
            if (grat_m > UNITY)
                grat_m = UNITY;
            grat_neg = (sn < 0) != (sd < 0);
        end
        prod = (sinc_m * grat_m) >> 30;
        neg  = (sinc_neg != grat_neg) && prod != 0;
        amp  = ({32'd0, peak_amp} * prod) >> 30;
        if (!neg) begin
            res.amp = (amp > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(amp);
        end else begin
            lim     = (amp > 64'h8000_0000) ? 64'h8000_0000 : amp;
            res.amp = 32'(-lim);
        end
        res.irr = (amp >= 64'h100_0000) ? 32'hFFFF_FFFF : 32'((amp * amp) >> 16);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
        errors++;
    endtask

    // check each strobed result against the oldest expectation
    always @(posedge i_clk) begin
        t_pattern want;
        if (i_rst_n && o_valid) begin
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected result", o_amplitude, 32'd0);
            end else begin
                want = pending_q.pop_front();
                if (o_amplitude !== want.amp)
                    report_mismatch("amplitude", o_amplitude, want.amp);
                if (o_irradiance !== want.irr)
                    report_mismatch("irradiance", o_irradiance, want.irr);
            end
        end
    end

    // end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_SLIT_COUNT:   n_slits   = data[10:0];
            CFG_PEAK_AMP:     peak_amp  = data;
            CFG_SLIT_WIDTH:   width_b   = data;
            CFG_SLIT_SPACING: spacing_d = data;
            CFG_WAVE_NUMBER:  wave_k    = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // present one angle, hold it until taken, then queue what it must produce
    task automatic send_angle(input logic signed [15:0] angle, input bit typed,
                              input t_pattern typed_res);
        @(negedge i_clk);
        while (idle_on && $urandom_range(99) < 12) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start   <= 1'b1;
        i_angle <= angle;
        do @(posedge i_clk); while (busy);
        pending_q.push_back(typed ? typed_res : diffraction_at(angle));
    endtask

    task automatic drain;
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] random_angle;
        if ($urandom_range(9) == 0)
            return 16'($urandom);
        return 16'(int'($urandom_range(51472)) - 25736);
    endfunction

    function automatic logic [31:0] random_q16;
        case ($urandom_range(5))
            0: return 32'($urandom);
            1: return ($urandom_range(1) == 0) ? 32'd0 : 32'hFFFF_FFFF;
            2: return 32'($urandom_range(32'h40_0000));
            default: return 32'($urandom_range(32'h8_0000));
        endcase
    endfunction

    t_row     rows[$];
    t_pattern fixed;
    int       phase, k;

    function automatic t_row put(input logic signed [15:0] angle);
        t_row r;
        r = '{1'b0, CFG_SLIT_COUNT, 32'd0, angle, 1'b0, 32'd0, 32'd0};
        return r;
    endfunction

    function automatic t_row put_typed(input logic signed [15:0] angle,
                                       input logic [31:0] amp, input logic [31:0] irr);
        t_row r;
        r = '{1'b0, CFG_SLIT_COUNT, 32'd0, angle, 1'b1, amp, irr};
        return r;
    endfunction

    function automatic t_row setreg(input t_cfg_idx idx, input logic [31:0] data);
        t_row r;
        r = '{1'b1, idx, data, 16'sd0, 1'b0, 32'd0, 32'd0};
        return r;
    endfunction

    initial begin
        start      <= 1'b0;
        i_angle    <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_SLIT_COUNT;
        i_cfg_data <= '0;
        i_rst_n    <= 1'b0;
        errors     = 0;
        idle_on    = 1'b1;
        n_slits    = RST_SLIT_COUNT;
        peak_amp   = RST_PEAK_AMP;
        width_b    = RST_SLIT_WIDTH;
        spacing_d  = RST_SLIT_SPACING;
        wave_k     = RST_WAVE_NUMBER;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes of the angle, slit count limits, saturation, wrap
        rows.push_back(put_typed(16'sd0, 32'h0001_0000, 32'h0001_0000));
        rows.push_back(put(16'sd25736));
        rows.push_back(put(-16'sd25736));
        rows.push_back(put(16'sh7FFF));
        rows.push_back(put(16'sh8000));
        rows.push_back(put(16'sd1));
        rows.push_back(put(-16'sd1));
        rows.push_back(put(16'sd16384));
        rows.push_back(setreg(CFG_SLIT_COUNT, 32'd0));
        rows.push_back(put(16'sd12000));
        rows.push_back(setreg(CFG_SLIT_COUNT, 32'd2047));
        rows.push_back(put(16'sd5000));
        rows.push_back(setreg(CFG_PEAK_AMP, 32'hFFFF_FFFF));
        rows.push_back(put_typed(16'sd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
        rows.push_back(put(-16'sd700));
        rows.push_back(setreg(CFG_WAVE_NUMBER, 32'hFFFF_FFFF));
        rows.push_back(setreg(CFG_SLIT_WIDTH, 32'hFFFF_FFFF));
        rows.push_back(setreg(CFG_SLIT_SPACING, 32'hFFFF_FFFF));
        rows.push_back(put(16'sd25736));
        rows.push_back(put(-16'sd3000));
        rows.push_back(put(16'sd77));
        rows.push_back(setreg(CFG_PEAK_AMP, 32'd0));
        rows.push_back(put_typed(16'sd9000, 32'd0, 32'd0));
        foreach (rows[i]) begin
            if (rows[i].is_write) begin
                drain();
                write_reg(rows[i].idx, rows[i].data);
            end else begin
                fixed.amp = rows[i].amp;
                fixed.irr = rows[i].irr;
                send_angle(rows[i].angle, rows[i].typed, fixed);
            end
        end

        // random: new grating settings per phase, one phase without idling
        for (phase = 0; phase < 15; phase++) begin
            drain();
            write_reg(CFG_SLIT_COUNT, ($urandom_range(2) == 0) ? 32'($urandom_range(2047))
                                                               : 32'($urandom_range(1, 16)));
            write_reg(CFG_PEAK_AMP, random_q16());
            write_reg(CFG_SLIT_WIDTH, random_q16());
            write_reg(CFG_SLIT_SPACING, random_q16());
            write_reg(CFG_WAVE_NUMBER, random_q16());
            idle_on = (phase != 4);
            for (k = 0; k < 70; k++) begin
                if (k == 35 && phase == 7)
                    drain();
                send_angle(random_angle(), 1'b0, fixed);
            end
        end

        drain();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[filelist.f]
rtl/msdp_pkg.sv
rtl/msdp_delay.sv
rtl/msdp_sine.sv
rtl/msdp_turn.sv
rtl/msdp_div_cell.sv
rtl/msdp_divider.sv
rtl/multi_slit_diffraction_pattern_unit.sv
tb/tb_multi_slit_diffraction_pattern_unit.sv
